// ----- rtl/dhs_pkg.sv -----
// ----------------------------------------------------------------------------
// dhs_pkg: shared constants and types
// Fixed-point constants, the CORDIC arctangent table and pipeline flags.
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_BITS       = 12;
  localparam int OUT_BITS       = 8;
  localparam int CORDIC_STEPS   = 20;
  localparam int CORDIC_PREC    = 20;
  localparam int ZW             = 25;
  localparam int MAG_BITS       = 24;
  localparam int DEG90_Q16      = 90 * 65536;
  localparam int DEG180_Q16     = 180 * 65536;
  localparam int DEG360_Q8      = 360 * 256;
  localparam int PI_RATIO_Q24   = 16785726;
  localparam int HUE_MAX        = 180;
  localparam int SAT_MAX        = 255;
  localparam int MAXDISP_RESET  = 16;
  localparam int DIV_STEPS      = 8;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic ax_zero;
    logic ay_zero;
  } vec_flags_t;

  // Arctangent of 2^-i in degrees, 16 fraction bits.
  function automatic int atan_q16(input int i);
    int t;
    case (i)
      0:  t = 2949120;
      1:  t = 1740967;
      2:  t = 919879;
      3:  t = 466945;
      4:  t = 234379;
      5:  t = 117305;
      6:  t = 58666;
      7:  t = 29335;
      8:  t = 14668;
      9:  t = 7334;
      10: t = 3667;
      11: t = 1833;
      12: t = 917;
      13: t = 458;
      14: t = 229;
      15: t = 115;
      16: t = 57;
      17: t = 29;
      18: t = 14;
      19: t = 7;
      default: t = 0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/displacement_to_hue_saturation_top.sv -----
// ----------------------------------------------------------------------------
// displacement_to_hue_saturation_top
// Maps a displacement vector to hue (direction) and saturation (length).
// ----------------------------------------------------------------------------
// One vector is accepted every clock; busy is always low. Each result leaves
// on out_valid after the input registers, a stage chain as long as the larger of
// 20 CORDIC steps and COORD_BITS+9 square root steps, and the divider. The
// depth is set by the bit-serial square root and CORDIC
// stage chain followed by an 8-stage saturation divider. The receiver cannot
// stall the block. max_displacement is written through the cfg channel,
// which is always ready, and should only change while no vector is in flight.
module displacement_to_hue_saturation_top #(
  parameter int COORD_BITS = dhs_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  output logic                           out_valid,
  output logic [dhs_pkg::OUT_BITS-1:0]   out_hue,
  output logic [dhs_pkg::OUT_BITS-1:0]   out_saturation,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhs_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int C   = COORD_BITS;
  localparam int XW  = C + dhs_pkg::CORDIC_PREC + 3;
  localparam int VW  = 2 * C + 17;
  localparam int N   = C + 9;
  localparam int LW  = N;
  localparam int K   = (N > dhs_pkg::CORDIC_STEPS) ? N : dhs_pkg::CORDIC_STEPS;
  localparam int RW  = LW + 8;
  localparam int CW  = (RW > 28) ? RW : 28;
  localparam int ZW  = dhs_pkg::ZW;
  localparam int MW  = dhs_pkg::MAG_BITS;
  localparam int DS  = dhs_pkg::DIV_STEPS;
  localparam int LAT = K + 12;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [dhs_pkg::CFG_BITS-1:0] md_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= dhs_pkg::CFG_BITS'(dhs_pkg::MAXDISP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      md_r <= cfg_data;
    end
  end

  // Stage A: deltas and their magnitudes.
  logic              va_r;
  logic [C-1:0]      ax_r, ay_r;
  logic              dxn_r, dyn_r;
  logic signed [C:0] dx_nxt, dy_nxt;

  always_comb begin
    dx_nxt = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
    dy_nxt = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start && !busy;
    end
    dxn_r <= dx_nxt[C];
    dyn_r <= dy_nxt[C];
    ax_r  <= dx_nxt[C] ? C'(-dx_nxt) : dx_nxt[C-1:0];
    ay_r  <= dy_nxt[C] ? C'(-dy_nxt) : dy_nxt[C-1:0];
  end

  // Stage B: squares for the length.
  logic                vb_r;
  logic [2*C-1:0]      sqx_r, sqy_r;
  logic [C-1:0]        axb_r, ayb_r;
  dhs_pkg::vec_flags_t flb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
    axb_r <= ax_r;
    ayb_r <= ay_r;
    flb_r <= '{dx_neg: dxn_r, dy_neg: dyn_r, ax_zero: (ax_r == '0), ay_zero: (ay_r == '0)};
  end

  // Shared chain: each stage does a CORDIC step, a square root bit, or both.
  logic                vl_r [K+1];
  logic signed [XW-1:0] x_r [K+1];
  logic signed [XW-1:0] y_r [K+1];
  logic signed [ZW-1:0] z_r [K+1];
  logic [VW-1:0]       rem_r [K+1];
  logic [VW-1:0]       root_r [K+1];
  dhs_pkg::vec_flags_t fl_r [K+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else begin
      vl_r[0] <= vb_r;
    end
    x_r[0]    <= $signed({3'b000, axb_r, {dhs_pkg::CORDIC_PREC{1'b0}}});
    y_r[0]    <= $signed({3'b000, ayb_r, {dhs_pkg::CORDIC_PREC{1'b0}}});
    z_r[0]    <= '0;
    rem_r[0]  <= {({1'b0, sqx_r} + {1'b0, sqy_r}), 16'b0};
    root_r[0] <= '0;
    fl_r[0]   <= flb_r;
  end

  for (genvar k = 0; k < K; k++) begin : g_stage
    logic signed [XW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;
    logic [VW-1:0]        rem_nxt, root_nxt;

    if (k < dhs_pkg::CORDIC_STEPS) begin : g_cordic
      localparam logic signed [ZW-1:0] AT = ZW'(dhs_pkg::atan_q16(k));
      logic signed [XW-1:0] xs, ys;
      always_comb begin
        xs = x_r[k] >>> k;
        ys = y_r[k] >>> k;
        if (y_r[k] > 0) begin
          x_nxt = x_r[k] + ys;
          y_nxt = y_r[k] - xs;
          z_nxt = z_r[k] + AT;
        end else if (y_r[k] < 0) begin
          x_nxt = x_r[k] - ys;
          y_nxt = y_r[k] + xs;
          z_nxt = z_r[k] - AT;
        end else begin
          x_nxt = x_r[k];
          y_nxt = y_r[k];
          z_nxt = z_r[k];
        end
      end
    end else begin : g_cordic_idle
      always_comb begin
        x_nxt = x_r[k];
        y_nxt = y_r[k];
        z_nxt = z_r[k];
      end
    end

    if (k < N) begin : g_sqrt
      localparam logic [VW-1:0] BIT = VW'(1) << (2 * (N - 1 - k));
      logic [VW-1:0] trial;
      always_comb begin
        trial = root_r[k] + BIT;
        if (rem_r[k] >= trial) begin
          rem_nxt  = rem_r[k] - trial;
          root_nxt = (root_r[k] >> 1) + BIT;
        end else begin
          rem_nxt  = rem_r[k];
          root_nxt = root_r[k] >> 1;
        end
      end
    end else begin : g_sqrt_idle
      always_comb begin
        rem_nxt  = rem_r[k];
        root_nxt = root_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k+1] <= 1'b0;
      end else begin
        vl_r[k+1] <= vl_r[k];
      end
      x_r[k+1]    <= x_nxt;
      y_r[k+1]    <= y_nxt;
      z_r[k+1]    <= z_nxt;
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      fl_r[k+1]   <= fl_r[k];
    end
  end

  // Post stage 0: quadrant placement and the saturation numerator.
  logic [MW-1:0] a_q, mag_nxt;
  logic [LW-1:0] len;
  logic [CW-1:0] nn, dlim;
  logic [19:0]   dnom;

  assign dnom = {md_r, 8'b0};

  always_comb begin
    if (fl_r[K].ay_zero) begin
      a_q = '0;
    end else if (fl_r[K].ax_zero) begin
      a_q = MW'(dhs_pkg::DEG90_Q16);
    end else if (z_r[K] < 0) begin
      a_q = '0;
    end else if (z_r[K] > ZW'(dhs_pkg::DEG90_Q16)) begin
      a_q = MW'(dhs_pkg::DEG90_Q16);
    end else begin
      a_q = z_r[K][MW-1:0];
    end
    mag_nxt = fl_r[K].dx_neg ? (MW'(dhs_pkg::DEG180_Q16) - a_q) : a_q;
    len     = root_r[K][LW-1:0];
    nn      = (CW'(len) << 8) - CW'(len);
    dlim    = CW'(dnom) << 8;
  end

  logic                vd_r [DS+1];
  logic [CW-1:0]       drem_r [DS+1];
  logic [DS-1:0]       q_r [DS+1];
  logic                ovf_r [DS+1];
  logic                lz_r [DS+1];
  logic [MW-1:0]       mag_r;
  logic                neg_r, neg1_r;
  logic [2*MW-1:0]     prod_r;
  logic [7:0]          hue_r [2:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else begin
      vd_r[0] <= vl_r[K];
    end
    drem_r[0] <= nn;
    q_r[0]    <= '0;
    ovf_r[0]  <= (len != '0) && (nn >= dlim);
    lz_r[0]   <= (len == '0);
    mag_r     <= mag_nxt;
    neg_r     <= fl_r[K].dy_neg && (mag_nxt != '0);
  end

  // Angle scaling runs alongside the first divider steps.
  logic [2*MW:0] up_sum;
  logic [17:0]   ang_nxt;
  logic [8:0]    hue_w;

  always_comb begin
    up_sum = {1'b0, prod_r} + (2*MW+1)'(33'h0FFFFFFFF);
    if (neg1_r) begin
      ang_nxt = 18'(dhs_pkg::DEG360_Q8) - 18'(up_sum >> 32);
    end else begin
      ang_nxt = 18'(prod_r >> 32);
    end
    hue_w = ang_nxt[17:9];
  end

  // The pi ratio is just above 2^24 and needs one bit more than the angle.
  always_ff @(posedge clk) begin
    prod_r   <= mag_r * (MW+1)'(dhs_pkg::PI_RATIO_Q24);
    neg1_r   <= neg_r;
    hue_r[2] <= (hue_w > 9'(dhs_pkg::HUE_MAX)) ? 8'(dhs_pkg::HUE_MAX) : hue_w[7:0];
  end

  for (genvar j = 3; j <= DS; j++) begin : g_hue_dly
    always_ff @(posedge clk) begin
      hue_r[j] <= hue_r[j-1];
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [CW-1:0] dsh;
    logic          ge;
    always_comb begin
      dsh = CW'(dnom) << (DS - 1 - j);
      ge  = drem_r[j] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else begin
        vd_r[j+1] <= vd_r[j];
      end
      drem_r[j+1] <= ge ? (drem_r[j] - dsh) : drem_r[j];
      q_r[j+1]    <= q_r[j] | (ge ? (DS'(1) << (DS - 1 - j)) : '0);
      ovf_r[j+1]  <= ovf_r[j];
      lz_r[j+1]   <= lz_r[j];
    end
  end

  assign out_valid      = vd_r[DS];
  assign out_hue        = hue_r[DS];
  assign out_saturation = lz_r[DS]  ? '0 :
                          ovf_r[DS] ? 8'(dhs_pkg::SAT_MAX) : q_r[DS];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("vector accepted without a result at the fixed latency");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= 8'(dhs_pkg::HUE_MAX)))
    else $error("hue out of range");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && lz_r[DS]) |-> (out_saturation == '0))
    else $error("zero length vector gave nonzero saturation");

endmodule
